// ===== src/spr_pkg.sv =====
// Shared types, constants and the easing-curve function for the servo pulse ramp generator.
`default_nettype none

package spr_pkg;

  // Parameter defaults
  localparam int unsigned STEPS_DEF     = 100;
  localparam int unsigned TICK_MS_DEF   = 10;
  localparam int unsigned MAX_ANGLE_DEF = 180;

  // Field widths
  localparam int unsigned PULSE_W   = 12;
  localparam int unsigned DELTA_W   = 13;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned STEPNUM_W = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned EASE_W    = 17;

  localparam logic [PULSE_W-1:0] PULSE_MAX     = 12'd4095;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2500;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef enum logic {
    PROFILE_LINEAR = 1'b0,
    PROFILE_SMOOTH = 1'b1
  } profile_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE = 1'b0,
    CFG_MAX_PULSE = 1'b1
  } cfg_idx_e;

  // Load enables for the two angle-mapping stages
  typedef struct packed {
    logic s1;
    logic s2;
  } ld_t;

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  // sin^2 easing in Q16 from a Q30 phase u in [0, 1]; elaboration-time only
  function automatic logic [EASE_W-1:0] ease_q16(input logic [63:0] u);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] e;
    m  = (u >= HALF_Q30) ? (u - HALF_Q30) : (HALF_Q30 - u);
    x  = (PI_Q30 * m) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    r = (u >= HALF_Q30) ? (ONE_Q30 + s) : (ONE_Q30 - s);
    e = (r + (64'd1 << 14)) >> 15;
    if (e > 64'd65536) begin
      e = 64'd65536;
    end
    return e[EASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/spr_ease_rom.sv =====
// Constant sin^2 easing table, one Q16 entry per ramp step.
`default_nettype none

module spr_ease_rom #(
  parameter int unsigned STEPS = spr_pkg::STEPS_DEF
) (
  input  wire logic [$clog2(STEPS)-1:0]   idx_i,
  output logic      [spr_pkg::EASE_W-1:0] ease_o
);
  import spr_pkg::*;

  logic [EASE_W-1:0] rom [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_rom
    localparam logic [63:0] U = (64'(g) << 30) / 64'(STEPS - 1);
    assign rom[g] = ease_q16(U);
  end

  assign ease_o = rom[idx_i];

endmodule

`default_nettype wire

// ===== src/spr_angle_map.sv =====
// Two-stage angle to pulse-width mapping for the start and end angles of a ramp.
`default_nettype none

module spr_angle_map #(
  parameter int unsigned MAX_ANGLE = spr_pkg::MAX_ANGLE_DEF
) (
  input  wire logic                          clk_i,
  input  wire spr_pkg::ld_t                  ld_i,
  input  wire logic [spr_pkg::PULSE_W-1:0]   min_pulse_i,
  input  wire logic [spr_pkg::PULSE_W-1:0]   max_pulse_i,
  input  wire logic [spr_pkg::ANGLE_W-1:0]   start_angle_i,
  input  wire logic [spr_pkg::ANGLE_W-1:0]   end_angle_i,
  output logic      [spr_pkg::PULSE_W-1:0]   base_o,
  output logic      [spr_pkg::PULSE_W-1:0]   end_o
);
  import spr_pkg::*;

  // numerator bound: 4095*MAX_ANGLE + 255*4095, plus sign
  localparam int unsigned NUM_W = $clog2(4095 * (MAX_ANGLE + 255) + 1) + 1;
  localparam int unsigned MAG_W = NUM_W - 1;
  localparam int unsigned A_SH  = MAG_W + $clog2(MAX_ANGLE);
  localparam int unsigned MUL_W = MAG_W + 1;
  localparam logic [63:0] A_MUL = ((64'd1 << A_SH) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE);
  localparam int unsigned PRD_W = MAG_W + MUL_W;

  logic signed [NUM_W-1:0] min_term, diff, sa_s, ea_s;
  logic signed [NUM_W-1:0] num_a_d, num_b_d;
  logic signed [NUM_W-1:0] num_a_q, num_b_q;

  assign min_term = $signed(NUM_W'(min_pulse_i)) * $signed(NUM_W'(MAX_ANGLE));
  assign diff     = $signed(NUM_W'(max_pulse_i)) - $signed(NUM_W'(min_pulse_i));
  assign sa_s     = $signed(NUM_W'(start_angle_i));
  assign ea_s     = $signed(NUM_W'(end_angle_i));
  assign num_a_d  = min_term + sa_s * diff;
  assign num_b_d  = min_term + ea_s * diff;

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      num_a_q <= num_a_d;
      num_b_q <= num_b_d;
    end
  end

  // floor(num / MAX_ANGLE) by reciprocal, clamped to the pulse range
  function automatic logic [PULSE_W-1:0] to_width(input logic signed [NUM_W-1:0] num);
    logic [PRD_W-1:0] prod;
    logic [PRD_W-1:0] shf;
    logic [MAG_W-1:0] q;
    logic [PULSE_W-1:0] w;
    prod = PRD_W'(num[MAG_W-1:0]) * PRD_W'(A_MUL[MUL_W-1:0]);
    shf  = prod >> A_SH;
    q    = shf[MAG_W-1:0];
    if (num[NUM_W-1]) begin
      w = '0;
    end else if (q > MAG_W'(PULSE_MAX)) begin
      w = PULSE_MAX;
    end else begin
      w = q[PULSE_W-1:0];
    end
    return w;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      base_o <= to_width(num_a_q);
      end_o  <= to_width(num_b_q);
    end
  end

endmodule

`default_nettype wire

// ===== src/servo_pulse_ramp_generator.sv =====
// Top level of the servo pulse ramp generator: control, step pipeline and result register.
`default_nettype none

// A start transaction (mode 0) maps its start and end angles to pulse widths,
// min + angle*(max-min)/MAX_ANGLE truncated and clamped to 0..4095, and at once
// gives step 0 of a STEPS-step ramp on its channel. Tick transactions (mode 1)
// count down a wait of W = total_time_ms/(STEPS*TICK_MS) ticks (at least one);
// when it runs out the next step is given, and after the last step one more
// wait ends in a done result that repeats step STEPS-1. A start always drops
// the ramp in progress; ticks while idle give nothing. Step i is
// base + floor(delta*i/STEPS) for the linear profile or
// base + floor(delta*E(i)/65536) for the smooth one, E being a constant Q16
// sin^2 table. Throughput is one transaction per cycle while the output is not
// stalled. A result reaches the output register through the input register,
// control and angle product, angle reciprocal divide, step product, offset
// divide, then the final add and clamp. Ticks that give no result leave the
// pipe after the control stage. The input keeps taking transactions while a
// result waits on a stalled output until all five stages are occupied.
// The user writes min_pulse_us (index 0) and max_pulse_us (index 1) only while
// the block is idle, which it does not enforce; they apply from the next start.
module servo_pulse_ramp_generator #(
  parameter int unsigned STEPS     = spr_pkg::STEPS_DEF,
  parameter int unsigned TICK_MS   = spr_pkg::TICK_MS_DEF,
  parameter int unsigned MAX_ANGLE = spr_pkg::MAX_ANGLE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [spr_pkg::PULSE_W-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            mode_i,
  input  wire logic [spr_pkg::CHAN_W-1:0]      channel_i,
  input  wire logic [spr_pkg::ANGLE_W-1:0]     start_angle_i,
  input  wire logic [spr_pkg::ANGLE_W-1:0]     end_angle_i,
  input  wire logic                            profile_i,
  input  wire logic [spr_pkg::TIME_W-1:0]      total_time_ms_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [spr_pkg::CHAN_W-1:0]      out_channel_o,
  output logic      [spr_pkg::PULSE_W-1:0]     pulse_us_o,
  output logic      [spr_pkg::STEPNUM_W-1:0]   step_number_o,
  output logic                                 done_res_o
);
  import spr_pkg::*;

  localparam int unsigned IDX_W = $clog2(STEPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

  // wait length: floor(total / (STEPS*TICK_MS)) by reciprocal
  localparam int unsigned W_DIV = STEPS * TICK_MS;
  localparam int unsigned W_SH  = TIME_W + $clog2(W_DIV);
  localparam int unsigned W_MW  = TIME_W + 1;
  localparam logic [63:0] W_MUL = ((64'd1 << W_SH) + 64'(W_DIV) - 64'd1) / 64'(W_DIV);
  localparam int unsigned W_PW  = TIME_W + W_MW;

  // linear offset: floor(p / STEPS) on the magnitude
  localparam int unsigned LIN_N = $clog2(4096 * STEPS);
  localparam int unsigned L_SH  = LIN_N + $clog2(STEPS);
  localparam int unsigned L_MW  = LIN_N + 1;
  localparam logic [63:0] L_MUL = ((64'd1 << L_SH) + 64'(STEPS) - 64'd1) / 64'(STEPS);
  localparam int unsigned L_PW  = LIN_N + L_MW;

  localparam int unsigned FAC_W  = EASE_W + 1;
  localparam int unsigned PROD_W = DELTA_W + FAC_W;
  localparam int unsigned SUM_W  = PULSE_W + 2;

  // ---------------- configuration ----------------
  logic [PULSE_W-1:0] min_pulse_q, max_pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= MIN_PULSE_RST;
      max_pulse_q <= MAX_PULSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_PULSE: min_pulse_q <= cfg_wdata_i;
        CFG_MAX_PULSE: max_pulse_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic ld0, ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !out_valid_q || !out_stall_i;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ld0 = !v0_q || ld1;

  assign in_stall_o = !ld0;

  // ---------------- stage 0: input register ----------------
  mode_e              mode0_q;
  profile_e           prof0_q;
  logic [CHAN_W-1:0]  chan0_q;
  logic [ANGLE_W-1:0] sa0_q, ea0_q;
  logic [TIME_W-1:0]  total0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (ld0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      mode0_q  <= mode_e'(mode_i);
      prof0_q  <= profile_e'(profile_i);
      chan0_q  <= channel_i;
      sa0_q    <= start_angle_i;
      ea0_q    <= end_angle_i;
      total0_q <= total_time_ms_i;
    end
  end

  // ---------------- stage 1: ramp control ----------------
  logic               busy_q, busy_d;
  profile_e           ramp_prof_q, ramp_prof_d;
  logic [CHAN_W-1:0]  ramp_chan_q, ramp_chan_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [TIME_W-1:0]  wait_cnt_q, wait_cnt_d;
  logic [TIME_W-1:0]  wait_rld_q, wait_rld_d;

  logic [W_PW-1:0]    w_prod, w_shf;
  logic [TIME_W-1:0]  w_len;

  logic               emit1, start1, done1;
  logic [IDX_W-1:0]   idx1;
  logic               fire0;

  assign fire0 = v0_q && ld1;
  assign w_prod = W_PW'(total0_q) * W_PW'(W_MUL[W_MW-1:0]);
  assign w_shf  = w_prod >> W_SH;
  assign w_len  = (w_shf[TIME_W-1:0] == '0) ? TIME_W'(1) : w_shf[TIME_W-1:0];

  always_comb begin
    busy_d      = busy_q;
    ramp_prof_d = ramp_prof_q;
    ramp_chan_d = ramp_chan_q;
    step_d      = step_q;
    wait_cnt_d  = wait_cnt_q;
    wait_rld_d  = wait_rld_q;
    emit1       = 1'b0;
    start1      = 1'b0;
    done1       = 1'b0;
    idx1        = step_q;
    if (mode0_q == MODE_START) begin
      busy_d      = 1'b1;
      ramp_prof_d = prof0_q;
      ramp_chan_d = chan0_q;
      step_d      = '0;
      wait_cnt_d  = w_len;
      wait_rld_d  = w_len;
      emit1       = 1'b1;
      start1      = 1'b1;
      idx1        = '0;
    end else if (busy_q) begin
      if (wait_cnt_q > TIME_W'(1)) begin
        wait_cnt_d = wait_cnt_q - TIME_W'(1);
      end else begin
        wait_cnt_d = wait_rld_q;
        emit1      = 1'b1;
        if (step_q >= LAST_IDX) begin
          busy_d = 1'b0;
          done1  = 1'b1;
          idx1   = LAST_IDX;
        end else begin
          step_d = step_q + IDX_W'(1);
          idx1   = step_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ramp_prof_q <= PROFILE_LINEAR;
      ramp_chan_q <= '0;
      step_q      <= '0;
      wait_cnt_q  <= '0;
      wait_rld_q  <= '0;
    end else if (fire0) begin
      busy_q      <= busy_d;
      ramp_prof_q <= ramp_prof_d;
      ramp_chan_q <= ramp_chan_d;
      step_q      <= step_d;
      wait_cnt_q  <= wait_cnt_d;
      wait_rld_q  <= wait_rld_d;
    end
  end

  profile_e           prof1_q, prof2_q, prof3_q;
  logic [CHAN_W-1:0]  chan1_q, chan2_q, chan3_q, chan4_q;
  logic [IDX_W-1:0]   idx1_q, idx2_q, idx3_q, idx4_q;
  logic               start1_q, start2_q;
  logic               done1_q, done2_q, done3_q, done4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= v0_q && emit1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      prof1_q  <= ramp_prof_d;
      chan1_q  <= ramp_chan_d;
      idx1_q   <= idx1;
      start1_q <= start1;
      done1_q  <= done1;
    end
  end

  // ---------------- stages 1-2: angle to pulse width ----------------
  ld_t                angle_ld;
  logic [PULSE_W-1:0] base_w, end_w;

  assign angle_ld.s1 = ld1;
  assign angle_ld.s2 = ld2;

  spr_angle_map #(
    .MAX_ANGLE(MAX_ANGLE)
  ) u_angle_map (
    .clk_i,
    .ld_i          (angle_ld),
    .min_pulse_i   (min_pulse_q),
    .max_pulse_i   (max_pulse_q),
    .start_angle_i (sa0_q),
    .end_angle_i   (ea0_q),
    .base_o        (base_w),
    .end_o         (end_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      prof2_q  <= prof1_q;
      chan2_q  <= chan1_q;
      idx2_q   <= idx1_q;
      start2_q <= start1_q;
      done2_q  <= done1_q;
    end
  end

  // ---------------- stage 3: ramp endpoints and step product ----------------
  // A start passing this point replaces base and delta; later steps read them.
  logic [PULSE_W-1:0]        base_q, base_sel;
  logic signed [DELTA_W-1:0] delta_q, delta_sel, delta_new;
  logic [EASE_W-1:0]         ease;
  logic signed [FAC_W-1:0]   factor;
  logic signed [PROD_W-1:0]  prod_d, prod3_q;
  logic [PULSE_W-1:0]        base3_q;

  spr_ease_rom #(
    .STEPS(STEPS)
  ) u_ease_rom (
    .idx_i  (idx2_q),
    .ease_o (ease)
  );

  assign delta_new = $signed({1'b0, end_w}) - $signed({1'b0, base_w});
  assign base_sel  = start2_q ? base_w : base_q;
  assign delta_sel = start2_q ? delta_new : delta_q;
  assign factor    = (prof2_q == PROFILE_SMOOTH) ? $signed(FAC_W'(ease))
                                                 : $signed(FAC_W'(idx2_q));
  assign prod_d    = delta_sel * factor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      delta_q <= '0;
    end else if (v2_q && ld3 && start2_q) begin
      base_q  <= base_w;
      delta_q <= delta_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      prof3_q <= prof2_q;
      chan3_q <= chan2_q;
      idx3_q  <= idx2_q;
      done3_q <= done2_q;
      base3_q <= base_sel;
      prod3_q <= prod_d;
    end
  end

  // ---------------- stage 4: floor division of the product ----------------
  logic                      neg3;
  logic signed [PROD_W-1:0]  adj, shr16;
  logic [L_PW-1:0]           l_prod, l_shf;
  logic [DELTA_W-1:0]        lin_q;
  logic signed [DELTA_W-1:0] off_d, off4_q;
  logic [PULSE_W-1:0]        base4_q;

  assign neg3   = prod3_q[PROD_W-1];
  // floor of a negative quotient: -floor((-p + STEPS - 1) / STEPS)
  assign adj    = neg3 ? ($signed(PROD_W'(STEPS - 1)) - prod3_q) : prod3_q;
  assign l_prod = L_PW'(adj[LIN_N-1:0]) * L_PW'(L_MUL[L_MW-1:0]);
  assign l_shf  = l_prod >> L_SH;
  assign lin_q  = l_shf[DELTA_W-1:0];
  assign shr16  = prod3_q >>> 16;

  always_comb begin
    if (prof3_q == PROFILE_SMOOTH) begin
      off_d = shr16[DELTA_W-1:0];
    end else if (neg3) begin
      off_d = -$signed(lin_q);
    end else begin
      off_d = $signed(lin_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ld4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      chan4_q <= chan3_q;
      idx4_q  <= idx3_q;
      done4_q <= done3_q;
      base4_q <= base3_q;
      off4_q  <= off_d;
    end
  end

  // ---------------- stage 5: add, clamp, result register ----------------
  logic signed [SUM_W-1:0] sum;
  logic [PULSE_W-1:0]      pulse_d;
  logic [CHAN_W-1:0]       out_chan_q;
  logic [PULSE_W-1:0]      pulse_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic                    out_done_q;

  assign sum = $signed(SUM_W'(base4_q)) + SUM_W'(off4_q);

  always_comb begin
    if (sum < 0) begin
      pulse_d = '0;
    end else if (sum > $signed(SUM_W'(PULSE_MAX))) begin
      pulse_d = PULSE_MAX;
    end else begin
      pulse_d = sum[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld5) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      out_chan_q <= chan4_q;
      pulse_q    <= pulse_d;
      out_idx_q  <= idx4_q;
      out_done_q <= done4_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign pulse_us_o    = pulse_q;
  assign step_number_o = STEPNUM_W'(out_idx_q);
  assign done_res_o    = out_done_q;

endmodule

`default_nettype wire
